### rtl/core/wildcard_byte_pattern_scanner_defines.svh
// assertion macros shared by the scanner rtl
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner check failed");

// next-cycle implication, checked outside reset
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner check failed");

`endif

### rtl/core/wbps_pkg.sv
// types, constants and register codes of the byte pattern scanner
package wbps_pkg;

   localparam int DEF_MAX_PATTERN = 16;
   localparam int PATTERN_BYTES   = 16;
   localparam int ADDR_W          = 48;
   localparam int LEN_W           = 5;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_ADDR_W      = 5;

   // register index, taken from the address in units of eight bytes
   typedef enum logic [1:0] {
      REG_PATTERN_LOW  = 2'd0,
      REG_PATTERN_HIGH = 2'd1,
      REG_WILDCARD     = 2'd2,
      REG_LENGTH       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic [ADDR_W-1:0] byte_address;
      logic              region_start;
      logic              scan_start;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] match_address;
      logic              found;
   } rsp_type;

   // pattern set-up as stored by the register block
   typedef struct packed {
      logic [8*PATTERN_BYTES-1:0] pattern;
      logic [PATTERN_BYTES-1:0]   wild_mask;
      logic [LEN_W-1:0]           length;
   } cfg_type;

   // compare outcome for the byte being accepted
   typedef struct packed {
      logic             match;
      logic [LEN_W-1:0] length;
   } match_info_type;

endpackage

### rtl/core/wildcard_byte_pattern_scanner.sv
// Byte pattern scanner: one memory byte with its address per request, compared against a
// pattern of up to 16 bytes with per-byte wildcards. Every request yields exactly one
// response, in the cycle after acceptance; a request can be accepted every cycle,
// including while a response waits, as long as the response register is free or drains in
// that cycle. The rate of one byte per clock is set by the single compare pass: the window
// shift, 16 byte compares and the match address subtract all sit between the window
// registers and the response register. Only the first match of a scan raises hit, with
// the address of the first matched byte; found stays set until a request with scan_start.
// A request with region_start empties the window before its byte enters, so matches never
// cross regions. Registers sit at byte addresses 0, 8, 16 and 24 (pattern bytes 0..7,
// pattern bytes 8..15, wildcard mask, length) and should be written only while idle.
`include "wildcard_byte_pattern_scanner_defines.svh"

module wildcard_byte_pattern_scanner #(
   parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  wbps_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output wbps_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wbps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wbps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import wbps_pkg::*;

   cfg_type        cfg;
   match_info_type info;
   logic           accept;
   logic           found_ff;
   logic           found_in;
   logic           hit_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;
   rsp_type        rsp_data_in;

   wbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wbps_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .req     (req_data),
      .cfg     (cfg),
      .info    (info)
   );

   // request taken when the response register is free or drains now
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // first match of the scan only
   always_comb begin
      hit_in   = info.match && (!found_ff || req_data.scan_start);
      found_in = hit_in || (found_ff && !req_data.scan_start);
      rsp_data_in.hit   = hit_in;
      rsp_data_in.found = found_in;
      if (hit_in) begin
         rsp_data_in.match_address = req_data.byte_address -
                                     ADDR_W'(info.length - LEN_W'(1));
      end else begin
         rsp_data_in.match_address = '0;
      end
   end

   // found flag
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (accept) begin
         found_ff <= found_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `WBPS_ASSERT_NOW(a_hit_sets_found, clock, reset, rsp_valid_ff && rsp_data_ff.hit, rsp_data_ff.found)
   `WBPS_ASSERT_NOW(a_addr_zero_no_hit, clock, reset, rsp_valid_ff && !rsp_data_ff.hit, rsp_data_ff.match_address == '0)
   `WBPS_ASSERT_NEXT(a_found_sticky, clock, reset, accept && found_ff && !req_data.scan_start, found_ff)
   `WBPS_ASSERT_NOW(a_hit_only_first, clock, reset, accept && hit_in, !found_ff || req_data.scan_start)

endmodule

### rtl/core/wbps_csr.sv
// register block: pattern, wildcard mask and length behind the apb port
module wbps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wbps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wbps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output wbps_pkg::cfg_type                 cfg
);
   import wbps_pkg::*;

   logic [63:0]              pat_low_ff;
   logic [63:0]              pat_high_ff;
   logic [PATTERN_BYTES-1:0] wild_ff;
   logic [LEN_W-1:0]         len_ff;
   reg_index_type            index;
   logic                     wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         wild_ff     <= '0;
         len_ff      <= LEN_W'(1);
      end else if (wr_en) begin
         case (index)
            REG_PATTERN_LOW:  pat_low_ff  <= csr_pwdata[63:0];
            REG_PATTERN_HIGH: pat_high_ff <= csr_pwdata[63:0];
            REG_WILDCARD:     wild_ff     <= csr_pwdata[PATTERN_BYTES-1:0];
            REG_LENGTH:       len_ff      <= csr_pwdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      case (index)
         REG_PATTERN_LOW:  csr_prdata = CSR_DATA_W'(pat_low_ff);
         REG_PATTERN_HIGH: csr_prdata = CSR_DATA_W'(pat_high_ff);
         REG_WILDCARD:     csr_prdata = CSR_DATA_W'(wild_ff);
         REG_LENGTH:       csr_prdata = CSR_DATA_W'(len_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.pattern   = {pat_high_ff, pat_low_ff};
   assign cfg.wild_mask = wild_ff;
   assign cfg.length    = len_ff;

endmodule

### rtl/core/wbps_match.sv
// sliding byte window with fill count and parallel wildcard compare
module wbps_match #(
   parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  wbps_pkg::req_type        req,
   input  wbps_pkg::cfg_type        cfg,
   output wbps_pkg::match_info_type info
);
   import wbps_pkg::*;

   localparam int WIN_DEPTH = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
   localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam logic [LEN_W-1:0] CAP = LEN_W'(WIN_DEPTH);

   logic [7:0]       window_ff [WIN_DEPTH];
   logic [7:0]       window_in [WIN_DEPTH];
   logic [LEN_W-1:0] fill_ff;
   logic [LEN_W-1:0] fill_in;
   logic [LEN_W-1:0] fill_base;
   logic [LEN_W-1:0] len;
   logic [WIN_DEPTH-1:0] pos_ok;

   // effective length: zero acts as one, clamp to window depth
   always_comb begin
      if (cfg.length == '0) begin
         len = LEN_W'(1);
      end else if (cfg.length > CAP) begin
         len = CAP;
      end else begin
         len = cfg.length;
      end
   end

   // window after this byte goes in, newest byte at entry 0
   always_comb begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (k == 0) begin
            window_in[k] = req.data_byte;
         end else begin
            window_in[k] = window_ff[k-1];
         end
      end
   end

   // fill count, emptied on a new region and saturating at the depth
   always_comb begin
      fill_base = req.region_start ? '0 : fill_ff;
      fill_in   = (fill_base < CAP) ? fill_base + LEN_W'(1) : fill_base;
   end

   // per pattern position: unused, wildcard or equal byte
   always_comb begin
      logic [LEN_W-1:0] sel;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         sel       = len - LEN_W'(1) - LEN_W'(j);
         pos_ok[j] = (LEN_W'(j) >= len) || cfg.wild_mask[j] ||
                     (window_in[sel[IDX_W-1:0]] == cfg.pattern[8*j +: 8]);
      end
   end

   assign info.match  = (fill_in >= len) && (&pos_ok);
   assign info.length = len;

   // window shift
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (advance) begin
         fill_ff <= fill_in;
      end
   end

endmodule
